/* rtl/core/sobol_pkg.sv */
// Shared constants and helpers for the Sobol sample core.
`timescale 1ns / 1ps

package sobol_pkg;

    localparam int MATRIX_COLUMNS_DEFAULT = 64;

    localparam int TABLE_ADDR_W = 16;
    localparam int WORD_W       = 32;
    localparam int INDEX_W      = 64;
    localparam int DIM_W        = 10;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [WORD_W-1:0] HASH_MUL_A = 32'h3d20adea;
    localparam logic [WORD_W-1:0] HASH_MUL_B = 32'h05526c56;
    localparam logic [WORD_W-1:0] HASH_MUL_C = 32'h53a22864;
    localparam int                SEED_SHIFT = 16;

    function automatic logic [WORD_W-1:0] bit_reverse(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] r;
        for (int k = 0; k < WORD_W; k++) begin
            r[k] = x[WORD_W-1-k];
        end
        return r;
    endfunction

endpackage

/* rtl/core/sobol_sample_owen_scrambled_core.sv */
// Sobol sample core: direction table, column XOR scan and fast Owen scramble.
// A table write is done when the word is accepted and leaves the core idle; a sample scans
// the columns, runs the scramble steps when enabled, and waits in ST_DONE for a free output.
// The core takes no new word until a sample is through, and scans one column per cycle through
// the single table read port; the scramble steps then share one multiplier.
// Reset clears the sequencer and the output valid; the table stays undefined until written.
`timescale 1ns / 1ps

module sobol_sample_owen_scrambled_core #(
    parameter int MATRIX_COLUMNS = sobol_pkg::MATRIX_COLUMNS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic [sobol_pkg::TABLE_ADDR_W-1:0] s_table_address,
    input  logic [sobol_pkg::WORD_W-1:0]       s_table_word,
    input  logic [sobol_pkg::INDEX_W-1:0]      s_sample_index,
    input  logic [sobol_pkg::DIM_W-1:0]        s_sample_dimension,
    input  logic [sobol_pkg::WORD_W-1:0]       s_scramble_seed,
    input  logic                              s_scramble_enable,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sobol_pkg::WORD_W-1:0]       m_sample_fraction
);

    localparam int AW    = sobol_pkg::TABLE_ADDR_W;
    localparam int WW    = sobol_pkg::WORD_W;
    localparam int IW    = sobol_pkg::INDEX_W;
    localparam int COL_W = (MATRIX_COLUMNS > 1) ? $clog2(MATRIX_COLUMNS) : 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MATRIX_COLUMNS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MIX_A,
        ST_ADD_SEED,
        ST_MUL_SEED,
        ST_MIX_B,
        ST_MIX_C,
        ST_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [IW-1:0]   index_reg, index_next;
    logic [AW-1:0]   base_reg, base_next;
    logic [WW-1:0]   seed_reg, seed_next;
    logic            scramble_reg, scramble_next;
    logic [WW-1:0]   v_reg, v_next;
    logic            pend_sel_reg, pend_sel_next;
    logic            m_valid_reg, m_valid_next;
    logic [WW-1:0]   m_data_reg, m_data_next;

    logic [WW-1:0]   table_mem [0:(1 << AW)-1];
    logic [WW-1:0]   rd_data_reg;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;

    logic            s_fire;
    logic [AW-1:0]   base_full;
    logic [WW-1:0]   mul_b;
    logic [WW-1:0]   mul_lo;
    logic [WW-1:0]   acc_tap;
    logic            out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign wr_en     = s_fire && (s_opcode == sobol_pkg::OP_WRITE);
    assign rd_addr   = base_reg + AW'(col_reg);
    assign base_full = AW'(32'(s_sample_dimension) * 32'(MATRIX_COLUMNS));
    assign acc_tap   = pend_sel_reg ? rd_data_reg : '0;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid           = m_valid_reg;
    assign m_sample_fraction = m_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[s_table_address] <= s_table_word;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_comb begin
        case (state_reg)
            ST_MIX_A:    mul_b = sobol_pkg::HASH_MUL_A;
            ST_MUL_SEED: mul_b = {{(WW-sobol_pkg::SEED_SHIFT){1'b0}},
                                  seed_reg[WW-1:sobol_pkg::SEED_SHIFT]} | WW'(1);
            ST_MIX_B:    mul_b = sobol_pkg::HASH_MUL_B;
            ST_MIX_C:    mul_b = sobol_pkg::HASH_MUL_C;
            default:     mul_b = '0;
        endcase
    end

    assign mul_lo = v_reg * mul_b;

    always_comb begin
        state_next    = state_reg;
        col_next      = col_reg;
        index_next    = index_reg;
        base_next     = base_reg;
        seed_next     = seed_reg;
        scramble_next = scramble_reg;
        v_next        = v_reg;
        pend_sel_next = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_opcode == sobol_pkg::OP_SAMPLE)) begin
                    index_next    = s_sample_index;
                    base_next     = base_full;
                    seed_next     = s_scramble_seed;
                    scramble_next = s_scramble_enable;
                    v_next        = '0;
                    col_next      = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                v_next        = v_reg ^ acc_tap;
                pend_sel_next = index_reg[0];
                index_next    = index_reg >> 1;
                if (col_reg == COL_LAST) begin
                    state_next = ST_DRAIN;
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            ST_DRAIN: begin
                if (scramble_reg) begin
                    v_next     = sobol_pkg::bit_reverse(v_reg ^ acc_tap);
                    state_next = ST_MIX_A;
                end else begin
                    v_next     = v_reg ^ acc_tap;
                    state_next = ST_DONE;
                end
            end
            ST_MIX_A: begin
                v_next     = v_reg ^ mul_lo;
                state_next = ST_ADD_SEED;
            end
            ST_ADD_SEED: begin
                v_next     = v_reg + seed_reg;
                state_next = ST_MUL_SEED;
            end
            ST_MUL_SEED: begin
                v_next     = mul_lo;
                state_next = ST_MIX_B;
            end
            ST_MIX_B: begin
                v_next     = v_reg ^ mul_lo;
                state_next = ST_MIX_C;
            end
            ST_MIX_C: begin
                v_next     = sobol_pkg::bit_reverse(v_reg ^ mul_lo);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = v_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            pend_sel_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            pend_sel_reg <= pend_sel_next;
        end
        col_reg      <= col_next;
        index_reg    <= index_next;
        base_reg     <= base_next;
        seed_reg     <= seed_next;
        scramble_reg <= scramble_next;
        v_reg        <= v_next;
        m_data_reg   <= m_data_next;
    end

    a_sample_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_opcode == sobol_pkg::OP_SAMPLE)) |=> (state_reg == ST_SCAN))
        else $error("sample word did not start the column scan");

    a_write_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_opcode == sobol_pkg::OP_WRITE)) |=> (state_reg == ST_IDLE))
        else $error("table write left the idle state");

    a_scan_ends_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && col_reg == COL_LAST) |=> (state_reg == ST_DRAIN))
        else $error("column scan did not end after the last column");

    a_done_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished sample was not moved to the output register");

endmodule

/* tb/sv/tb.sv */
// Testbench for the Sobol sample core: table loads, scrambled and raw samples, checked in order.
`timescale 1ns / 1ps

module tb;

    localparam int COLS = sobol_pkg::MATRIX_COLUMNS_DEFAULT;
    localparam int AW = sobol_pkg::TABLE_ADDR_W;
    localparam int DW = sobol_pkg::DIM_W;
    localparam int N_RANDOM = 920;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic                               opcode;
        logic [sobol_pkg::TABLE_ADDR_W-1:0] addr;
        logic [sobol_pkg::WORD_W-1:0]       word;
        logic [sobol_pkg::INDEX_W-1:0]      idx;
        logic [sobol_pkg::DIM_W-1:0]        dim;
        logic [sobol_pkg::WORD_W-1:0]       seed;
        logic                               scramble;
        logic                               typed;
        logic [sobol_pkg::WORD_W-1:0]       fraction;
    } stim_row_t;

    localparam logic [sobol_pkg::DIM_W-1:0] LOADED_DIMS [8] = '{
        10'd0, 10'd1, 10'd341, 10'd511, 10'd512, 10'd682, 10'd1022, 10'd1023
    };

    localparam int N_DIRECTED = 18;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{sobol_pkg::OP_WRITE,  16'h0000, 32'h8000_0000, 64'h0, 10'd0, 32'h0, 1'b0,
          1'b0, 32'h0},
        '{sobol_pkg::OP_WRITE,  16'hFFFF, 32'hFFFF_FFFF, '1, 10'h3FF, 32'hFFFF_FFFF, 1'b1,
          1'b0, 32'h0},
        '{sobol_pkg::OP_WRITE,  16'h0001, 32'h4000_0000, 64'h0, 10'd0, 32'h0, 1'b0,
          1'b0, 32'h0},
        '{sobol_pkg::OP_WRITE,  16'h003F, 32'h0000_0001, 64'h0, 10'd0, 32'h0, 1'b0,
          1'b0, 32'h0},
        '{sobol_pkg::OP_WRITE,  16'hFFC0, 32'h1234_5678, 64'h0, 10'd0, 32'h0, 1'b0,
          1'b0, 32'h0},
        '{sobol_pkg::OP_SAMPLE, 16'h0000, 32'h0, 64'h0, 10'd0, 32'h0, 1'b0,
          1'b1, 32'h0},
        '{sobol_pkg::OP_SAMPLE, 16'h0000, 32'h0, 64'h1, 10'd0, 32'h0, 1'b0,
          1'b1, 32'h8000_0000},
        '{sobol_pkg::OP_SAMPLE, 16'h0000, 32'h0, 64'h3, 10'd0, 32'h0, 1'b0,
          1'b1, 32'hC000_0000},
        '{sobol_pkg::OP_SAMPLE, 16'h0000, 32'h0, 64'h8000_0000_0000_0000, 10'd0, 32'h0,
          1'b0, 1'b1, 32'h0000_0001},
        '{sobol_pkg::OP_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000, 10'd1023,
          32'h0, 1'b0, 1'b1, 32'hFFFF_FFFF},
        '{sobol_pkg::OP_SAMPLE, 16'h0000, 32'h0, 64'h8000_0000_0000_0001, 10'd1023, 32'h0,
          1'b0, 1'b1, 32'hEDCB_A987},
        '{sobol_pkg::OP_SAMPLE, 16'h0000, 32'h0, 64'h0, 10'd0, 32'h0, 1'b1,
          1'b1, 32'h0},
        '{sobol_pkg::OP_SAMPLE, 16'h0000, 32'h0, 64'h0, 10'd0, 32'hFFFF_FFFF, 1'b1,
          1'b0, 32'h0},
        '{sobol_pkg::OP_SAMPLE, 16'h0000, 32'h0, 64'h8000_0000_0000_0003, 10'd0,
          32'h1234_5678, 1'b1, 1'b0, 32'h0},
        '{sobol_pkg::OP_SAMPLE, 16'h0000, 32'h0, 64'h8000_0000_0000_0001, 10'd1023,
          32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
        '{sobol_pkg::OP_WRITE,  16'h0000, 32'h0000_0000, 64'h0, 10'd0, 32'h0, 1'b0,
          1'b0, 32'h0},
        '{sobol_pkg::OP_SAMPLE, 16'h0000, 32'h0, 64'h1, 10'd0, 32'h0, 1'b0,
          1'b1, 32'h0},
        '{sobol_pkg::OP_SAMPLE, 16'h0000, 32'h0, 64'h8000_0000_0000_0003, 10'd0, 32'h0,
          1'b0, 1'b1, 32'h4000_0001}
    };

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic                               s_opcode;
    logic [sobol_pkg::TABLE_ADDR_W-1:0] s_table_address;
    logic [sobol_pkg::WORD_W-1:0]       s_table_word;
    logic [sobol_pkg::INDEX_W-1:0]      s_sample_index;
    logic [sobol_pkg::DIM_W-1:0]        s_sample_dimension;
    logic [sobol_pkg::WORD_W-1:0]       s_scramble_seed;
    logic                               s_scramble_enable;
    logic                               m_valid;
    logic                               m_ready;
    logic [sobol_pkg::WORD_W-1:0]       m_sample_fraction;

    logic [sobol_pkg::WORD_W-1:0] column_words [0:65535];
    bit                           column_loaded [0:65535];
    logic [sobol_pkg::WORD_W-1:0] pending_fractions [$];
    int                           mismatches = 0;
    int                           calm_items = 0;
    bit                           hold_off_req = 1'b0;

    sobol_sample_owen_scrambled_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_table_address    (s_table_address),
        .s_table_word       (s_table_word),
        .s_sample_index     (s_sample_index),
        .s_sample_dimension (s_sample_dimension),
        .s_scramble_seed    (s_scramble_seed),
        .s_scramble_enable  (s_scramble_enable),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_sample_fraction  (m_sample_fraction)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [sobol_pkg::INDEX_W-1:0] written_columns(
        input logic [sobol_pkg::DIM_W-1:0] dim);
        logic [sobol_pkg::INDEX_W-1:0]      m;
        logic [sobol_pkg::TABLE_ADDR_W-1:0] a;
        m = '0;
        for (int b = 0; b < COLS && b < sobol_pkg::INDEX_W; b++) begin
            a = AW'(dim * COLS + b);
            m[b] = column_loaded[a];
        end
        return m;
    endfunction

    function automatic logic [sobol_pkg::WORD_W-1:0] sobol_point(
        input logic [sobol_pkg::INDEX_W-1:0] idx,
        input logic [sobol_pkg::DIM_W-1:0] dim);
        logic [sobol_pkg::WORD_W-1:0]       v;
        logic [sobol_pkg::TABLE_ADDR_W-1:0] a;
        v = '0;
        for (int b = 0; b < COLS && b < sobol_pkg::INDEX_W; b++) begin
            a = AW'(dim * COLS + b);
            if (idx[b]) begin
                v ^= column_words[a];
            end
        end
        return v;
    endfunction

    function automatic logic [sobol_pkg::WORD_W-1:0] owen_scrambled(
        input logic [sobol_pkg::WORD_W-1:0] seed,
        input logic [sobol_pkg::WORD_W-1:0] raw);
        logic [sobol_pkg::WORD_W-1:0] v;
        v = {<<{raw}};
        v ^= v * sobol_pkg::HASH_MUL_A;
        v += seed;
        v *= (seed >> sobol_pkg::SEED_SHIFT) | 32'd1;
        v ^= v * sobol_pkg::HASH_MUL_B;
        v ^= v * sobol_pkg::HASH_MUL_C;
        return {<<{v}};
    endfunction

    function automatic stim_row_t random_word();
        stim_row_t w;
        w.opcode   = sobol_pkg::OP_SAMPLE;
        w.addr     = AW'($urandom);
        w.word     = $urandom;
        w.idx      = {$urandom, $urandom};
        w.dim      = DW'($urandom);
        w.seed     = $urandom;
        w.scramble = 1'($urandom_range(0, 1));
        w.typed    = 1'b0;
        w.fraction = '0;
        if ($urandom_range(0, 99) < 20) begin
            w.opcode = sobol_pkg::OP_WRITE;
            if ($urandom_range(0, 1) == 1) begin
                w.addr = AW'(LOADED_DIMS[$urandom_range(0, 7)] * COLS
                             + $urandom_range(0, COLS - 1));
            end
        end else begin
            if ($urandom_range(0, 99) < 80) begin
                w.dim = LOADED_DIMS[$urandom_range(0, 7)];
            end
            case ($urandom_range(0, 9))
                0: w.idx = '1;
                1: w.idx = '0;
                2: w.idx = 64'd1 << $urandom_range(0, sobol_pkg::INDEX_W - 1);
                3: w.idx = 64'($urandom_range(0, 1023));
                default: ;
            endcase
            case ($urandom_range(0, 5))
                0: w.seed = '0;
                1: w.seed = '1;
                default: ;
            endcase
            // keep clear of table entries never written
            w.idx &= written_columns(w.dim);
        end
        return w;
    endfunction

    task automatic note_accepted(input stim_row_t w);
        logic [sobol_pkg::WORD_W-1:0] v;
        if (w.opcode == sobol_pkg::OP_WRITE) begin
            column_words[w.addr]  = w.word;
            column_loaded[w.addr] = 1'b1;
        end else if (w.typed) begin
            pending_fractions.push_back(w.fraction);
        end else begin
            v = sobol_point(w.idx, w.dim);
            if (w.scramble) begin
                v = owen_scrambled(w.seed, v);
            end
            pending_fractions.push_back(v);
        end
    endtask

    task automatic offer_word(input stim_row_t w);
        s_valid            <= 1'b1;
        s_opcode           <= w.opcode;
        s_table_address    <= w.addr;
        s_table_word       <= w.word;
        s_sample_index     <= w.idx;
        s_sample_dimension <= w.dim;
        s_scramble_seed    <= w.seed;
        s_scramble_enable  <= w.scramble;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        note_accepted(w);
    endtask

    task automatic sender_pause();
        int gap;
        int roll;
        gap = 0;
        if (calm_items > 0) begin
            calm_items--;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                calm_items = $urandom_range(30, 100);
            end else if (roll < 10) begin
                gap = $urandom_range(10, 40);
            end else if (roll < 40) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin : word_source
        stim_row_t w;
        aresetn            <= 1'b0;
        s_valid            <= 1'b0;
        s_opcode           <= sobol_pkg::OP_WRITE;
        s_table_address    <= '0;
        s_table_word       <= '0;
        s_sample_index     <= '0;
        s_sample_dimension <= '0;
        s_scramble_seed    <= '0;
        s_scramble_enable  <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            offer_word(DIRECTED[i]);
            sender_pause();
        end

        for (int k = 0; k < 8; k++) begin
            for (int b = 0; b < COLS; b++) begin
                w          = random_word();
                w.opcode   = sobol_pkg::OP_WRITE;
                w.addr     = AW'(LOADED_DIMS[k] * COLS + b);
                offer_word(w);
                sender_pause();
            end
        end

        // stall the result side while words keep coming
        hold_off_req = 1'b1;
        repeat (N_RANDOM) begin
            w = random_word();
            offer_word(w);
            sender_pause();
        end
        s_valid <= 1'b0;

        while (pending_fractions.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : result_sink
        int stall_left;
        int calm_left;
        int roll;
        bit hold_off_seen;
        logic [sobol_pkg::WORD_W-1:0] want;
        stall_left    = 0;
        calm_left     = 0;
        hold_off_seen = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_fractions.size() == 0) begin
                    $error("unexpected result word: sample_fraction %h", m_sample_fraction);
                    mismatches++;
                end else begin
                    want = pending_fractions.pop_front();
                    if (m_sample_fraction !== want) begin
                        $error("sample_fraction: expected %h, actual %h",
                               want, m_sample_fraction);
                        mismatches++;
                    end
                end
            end
            if (hold_off_req && !hold_off_seen) begin
                hold_off_seen = 1'b1;
                stall_left    = HOLD_OFF_CYCLES;
                calm_left     = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                m_ready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    calm_left = $urandom_range(50, 300);
                end else if (roll < 8) begin
                    stall_left = $urandom_range(20, 80);
                end else if (roll < 30) begin
                    stall_left = $urandom_range(1, 3);
                end
                m_ready <= (stall_left == 0);
            end
        end
    end

endmodule

/* sim.f */
rtl/core/sobol_pkg.sv
rtl/core/sobol_sample_owen_scrambled_core.sv
tb/sv/tb.sv
